>>> hdl/bknt_pkg.sv
// Shared types and constants for the BSSID-keyed network table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bknt_pkg;

  localparam int MAX_NETWORKS = 16;
  localparam int IDX_W        = $clog2(MAX_NETWORKS);
  localparam int CNT_W        = $clog2(MAX_NETWORKS + 1);
  localparam int KEY_W        = 48;
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 4;

  typedef enum logic [1:0] {
    ST_IGNORED   = 2'd0,
    ST_REFRESHED = 2'd1,
    ST_APPENDED  = 2'd2,
    ST_DROPPED   = 2'd3
  } upd_status_t;

  // One stored network entry.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [BYTE_W-1:0] signal;
    logic [BYTE_W-1:0] security;
    logic [BYTE_W-1:0] channel;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch_item;
    logic        rd_en;
    logic        idx_inc;
    logic        wr_hit;
    logic        wr_append;
    logic        res_set;
    upd_status_t res_status;
    logic        res_found;
    logic        load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic key_zero;
    logic key_match;
    logic pos_valid;
    logic idx_last;
    logic table_full;
    logic count_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/bknt_ctrl.sv
// Controller state machine of the network table: sequences lookup, write and result.
// Depends on bknt_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bknt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bknt_pkg::stat_t stat,
  output bknt_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_query) begin
          if (stat.pos_valid) begin
            cmd.rd_en  = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.res_set    = 1'b1;
            cmd.res_status = bknt_pkg::ST_IGNORED;
            state_next     = S_RESULT;
          end
        end else if (stat.key_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_IGNORED;
          state_next     = S_RESULT;
        end else if (stat.count_zero) begin
          cmd.wr_append  = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_APPENDED;
          state_next     = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_query) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_IGNORED;
          cmd.res_found  = 1'b1;
          state_next     = S_RESULT;
        end else if (stat.key_match) begin
          cmd.wr_hit     = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_REFRESHED;
          state_next     = S_RESULT;
        end else if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end else if (stat.table_full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_DROPPED;
          state_next     = S_RESULT;
        end else begin
          cmd.wr_append  = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = bknt_pkg::ST_APPENDED;
          state_next     = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A refresh and an append never target the table in the same cycle.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_hit && cmd.wr_append))
    else $error("refresh and append issued together");

  // An append is only issued while the table still has room.
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_append |-> !stat.table_full)
    else $error("append issued on a full table");

  // A found query result comes only from a query whose position was valid.
  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_set && cmd.res_found) |-> (stat.is_query && stat.pos_valid))
    else $error("found reported for an invalid query");

endmodule

`default_nettype wire

>>> hdl/bknt_dpath.sv
// Datapath of the network table: item registers, entry memory, count, output register.
// Depends on bknt_pkg; driven by bknt_ctrl through cmd_t and reports through stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bknt_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bknt_pkg::cmd_t               cmd,
  output bknt_pkg::stat_t                   stat,
  input  wire logic                         operation,
  input  wire logic [bknt_pkg::KEY_W-1:0]   bssid,
  input  wire logic signed [bknt_pkg::BYTE_W-1:0] signal_strength,
  input  wire logic [bknt_pkg::BYTE_W-1:0]  security_type,
  input  wire logic [bknt_pkg::BYTE_W-1:0]  radio_channel,
  input  wire logic [bknt_pkg::POS_W-1:0]   position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        update_status,
  output logic                              found,
  output logic [bknt_pkg::CNT_W-1:0]        entry_total,
  output logic [bknt_pkg::KEY_W-1:0]        bssid_out,
  output logic signed [bknt_pkg::BYTE_W-1:0] signal_out,
  output logic [bknt_pkg::BYTE_W-1:0]       security_out,
  output logic [bknt_pkg::BYTE_W-1:0]       channel_out
);

  // Latched item.
  logic                          item_query;
  bknt_pkg::entry_t              item_entry;
  logic [bknt_pkg::POS_W-1:0]    item_pos;

  // Table state.
  bknt_pkg::entry_t              mem [bknt_pkg::MAX_NETWORKS];
  bknt_pkg::entry_t              rd_data;
  logic [bknt_pkg::IDX_W-1:0]    idx;
  logic [bknt_pkg::CNT_W-1:0]    count;

  // Staged result.
  logic [1:0]                    res_status;
  logic                          res_found;
  bknt_pkg::entry_t              res_entry;
  bknt_pkg::entry_t              out_entry;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_query          <= operation;
      item_entry.key      <= bssid;
      item_entry.signal   <= signal_strength;
      item_entry.security <= security_type;
      item_entry.channel  <= radio_channel;
      item_pos            <= position;
    end
  end

  // Walk index: starts at the queried position or at the first entry.
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      idx <= operation ? bknt_pkg::IDX_W'(position) : '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_hit) begin
      mem[idx] <= item_entry;
    end else if (cmd.wr_append) begin
      mem[count[bknt_pkg::IDX_W-1:0]] <= item_entry;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_append) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_found;
      res_entry  <= cmd.res_found ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      update_status <= res_status;
      found         <= res_found;
      entry_total   <= count;
      out_entry     <= res_entry;
    end
  end

  assign bssid_out    = out_entry.key;
  assign signal_out   = $signed(out_entry.signal);
  assign security_out = out_entry.security;
  assign channel_out  = out_entry.channel;

  always_comb begin
    stat.is_query   = item_query;
    stat.key_zero   = (item_entry.key == '0);
    stat.key_match  = (rd_data.key == item_entry.key);
    stat.pos_valid  = (bknt_pkg::CNT_W'(item_pos) < count);
    stat.idx_last   = ((bknt_pkg::CNT_W'(idx) + 1'b1) >= count);
    stat.table_full = (count == bknt_pkg::CNT_W'(bknt_pkg::MAX_NETWORKS));
    stat.count_zero = (count == '0);
    stat.out_free   = !out_valid || out_ready;
  end

  // The entry count never passes the table size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= bknt_pkg::CNT_W'(bknt_pkg::MAX_NETWORKS))
    else $error("entry count beyond table size");

  // An append raises the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_append |=> count == $past(count) + 1'b1)
    else $error("append did not raise the count by one");

  // A new result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transaction");

endmodule

`default_nettype wire

>>> hdl/bssid_keyed_network_table_core.sv
// A query with a valid position reads its entry and returns it; a query past the count,
// a zero key or an append to an empty table goes straight to the result; other updates
// walk the stored keys, with one registered read, then one compare, per key.
// One item is in work at a time; the next input transaction is taken in the cycle after its
// result is loaded, and loading waits while an earlier result is still pending.
// Reset clears the state machine, entry count and output valid; entries stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module bssid_keyed_network_table_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         operation,
  input  wire logic [bknt_pkg::KEY_W-1:0]   bssid,
  input  wire logic signed [bknt_pkg::BYTE_W-1:0] signal_strength,
  input  wire logic [bknt_pkg::BYTE_W-1:0]  security_type,
  input  wire logic [bknt_pkg::BYTE_W-1:0]  radio_channel,
  input  wire logic [bknt_pkg::POS_W-1:0]   position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        update_status,
  output logic                              found,
  output logic [bknt_pkg::CNT_W-1:0]        entry_total,
  output logic [bknt_pkg::KEY_W-1:0]        bssid_out,
  output logic signed [bknt_pkg::BYTE_W-1:0] signal_out,
  output logic [bknt_pkg::BYTE_W-1:0]       security_out,
  output logic [bknt_pkg::BYTE_W-1:0]       channel_out
);

  // The controller walks the stored keys one at a time; the datapath holds the
  // item, the entry memory with its registered read port, the entry count and
  // the output register. Because the output register is separate, a new input
  // transaction is taken while the previous result still waits to be taken.
  bknt_pkg::cmd_t  cmd;
  bknt_pkg::stat_t stat;

  bknt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bknt_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .operation       (operation),
    .bssid           (bssid),
    .signal_strength (signal_strength),
    .security_type   (security_type),
    .radio_channel   (radio_channel),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .update_status   (update_status),
    .found           (found),
    .entry_total     (entry_total),
    .bssid_out       (bssid_out),
    .signal_out      (signal_out),
    .security_out    (security_out),
    .channel_out     (channel_out)
  );

endmodule

`default_nettype wire

>>> test/bssid_keyed_network_table_core_test.sv
// Self-checking testbench for the BSSID-keyed network table core.
// It depends on bknt_pkg and bssid_keyed_network_table_core. A directed table runs first,
// then random scan traffic, all checked against a table predictor kept in this module.
`timescale 1ns / 1ps

module bssid_keyed_network_table_core_test;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam int N_DIRECTED  = 27;
  localparam int N_RANDOM    = 1123;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 40;   // longer than the slowest update
  localparam int PRINT_LIMIT = 40;

  // One scan result or query, as it goes into the block.
  typedef struct packed {
    logic                               op;
    logic [bknt_pkg::KEY_W-1:0]         key;
    logic signed [bknt_pkg::BYTE_W-1:0] sig;
    logic [bknt_pkg::BYTE_W-1:0]        sec;
    logic [bknt_pkg::BYTE_W-1:0]        chan;
    logic [bknt_pkg::POS_W-1:0]         pos;
  } scan_item_t;

  // One result transaction, as it comes out of the block.
  typedef struct packed {
    bknt_pkg::upd_status_t      status;
    logic                       found;
    logic [bknt_pkg::CNT_W-1:0] total;
    bknt_pkg::entry_t           entry;
  } table_result_t;

  typedef struct {
    scan_item_t    item;
    bit            typed;
    table_result_t want;
  } directed_row_t;

  typedef enum logic [1:0] {
    DRAIN_ALWAYS,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_PERIODIC
  } drain_mode_t;

  localparam table_result_t NONE = '0;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               operation = 1'b0;
  logic [bknt_pkg::KEY_W-1:0]         bssid = '0;
  logic signed [bknt_pkg::BYTE_W-1:0] signal_strength = '0;
  logic [bknt_pkg::BYTE_W-1:0]        security_type = '0;
  logic [bknt_pkg::BYTE_W-1:0]        radio_channel = '0;
  logic [bknt_pkg::POS_W-1:0]         position = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [1:0]                         update_status;
  logic                               found;
  logic [bknt_pkg::CNT_W-1:0]         entry_total;
  logic [bknt_pkg::KEY_W-1:0]         bssid_out;
  logic signed [bknt_pkg::BYTE_W-1:0] signal_out;
  logic [bknt_pkg::BYTE_W-1:0]        security_out;
  logic [bknt_pkg::BYTE_W-1:0]        channel_out;

  bssid_keyed_network_table_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .bssid           (bssid),
    .signal_strength (signal_strength),
    .security_type   (security_type),
    .radio_channel   (radio_channel),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .update_status   (update_status),
    .found           (found),
    .entry_total     (entry_total),
    .bssid_out       (bssid_out),
    .signal_out      (signal_out),
    .security_out    (security_out),
    .channel_out     (channel_out)
  );

  always #5 clk = ~clk;

  // Predictor copy of the network table.
  bknt_pkg::entry_t           net_entries [bknt_pkg::MAX_NETWORKS];
  logic [bknt_pkg::CNT_W-1:0] net_count = '0;

  table_result_t expected_results [$];
  table_result_t want_now;

  int unsigned cycle_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          random_done = 0;
  int          status_count [4] = '{0, 0, 0, 0};
  int          query_hits = 0;
  int          query_misses = 0;
  drain_mode_t drain_mode = DRAIN_ALWAYS;

  // Directed rows. Rows marked 1 carry an expectation typed in by hand; rows marked 0
  // take the predictor's answer. The table fills to capacity here, so the dropped case and
  // a refresh of the very last entry are both reached before random traffic starts.
  directed_row_t directed_rows [N_DIRECTED] = '{
    // Fresh table: queries miss, and a zero key is ignored.
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 0}, 1,
      '{bknt_pkg::ST_IGNORED, 0, 0, '{0, 0, 0, 0}}},
    '{'{OP_QUERY,  48'hFFFF_FFFF_FFFF, -1, 255, 255, 15}, 1,
      '{bknt_pkg::ST_IGNORED, 0, 0, '{0, 0, 0, 0}}},
    '{'{OP_UPDATE, 48'h0, 127, 255, 255, 15}, 1,
      '{bknt_pkg::ST_IGNORED, 0, 0, '{0, 0, 0, 0}}},
    // All-ones key with the most negative signal.
    '{'{OP_UPDATE, 48'hFFFF_FFFF_FFFF, -128, 255, 255, 0}, 1,
      '{bknt_pkg::ST_APPENDED, 0, 1, '{0, 0, 0, 0}}},
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 0}, 1,
      '{bknt_pkg::ST_IGNORED, 1, 1, '{48'hFFFF_FFFF_FFFF, 8'h80, 8'hFF, 8'hFF}}},
    '{'{OP_UPDATE, 48'h0000_0000_0001, 127, 0, 0, 7}, 1,
      '{bknt_pkg::ST_APPENDED, 0, 2, '{0, 0, 0, 0}}},
    '{'{OP_UPDATE, 48'hFFFF_FFFF_FFFF, 0, 6, 6, 3}, 1,
      '{bknt_pkg::ST_REFRESHED, 0, 2, '{0, 0, 0, 0}}},
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 0}, 0, NONE},
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 1}, 0, NONE},
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 2}, 1,
      '{bknt_pkg::ST_IGNORED, 0, 2, '{0, 0, 0, 0}}},
    // Fill the remaining fourteen slots; two keys are a single bit away from stored ones.
    '{'{OP_UPDATE, 48'h8000_0000_0000, -90, 3, 1, 0}, 0, NONE},
    '{'{OP_UPDATE, 48'hFFFF_FFFF_FFFE, -45, 4, 6, 9}, 0, NONE},
    '{'{OP_UPDATE, 48'h5555_5555_5555, -70, 85, 11, 5}, 0, NONE},
    '{'{OP_UPDATE, 48'hAAAA_AAAA_AAAA, -30, 170, 36, 10}, 0, NONE},
    '{'{OP_UPDATE, 48'h0000_0000_0002, -100, 2, 40, 1}, 0, NONE},
    '{'{OP_UPDATE, 48'h0000_0001_0000, 10, 7, 44, 14}, 0, NONE},
    '{'{OP_UPDATE, 48'h0123_4567_89AB, -60, 1, 149, 2}, 0, NONE},
    '{'{OP_UPDATE, 48'hFEDC_BA98_7654, -20, 8, 153, 13}, 0, NONE},
    '{'{OP_UPDATE, 48'h0000_FFFF_0000, -75, 9, 157, 4}, 0, NONE},
    '{'{OP_UPDATE, 48'hFFFF_0000_FFFF, -55, 128, 161, 11}, 0, NONE},
    '{'{OP_UPDATE, 48'h7FFF_FFFF_FFFF, -1, 127, 165, 6}, 0, NONE},
    '{'{OP_UPDATE, 48'h0000_0000_0100, 0, 64, 13, 8}, 0, NONE},
    '{'{OP_UPDATE, 48'h1357_9BDF_2468, -82, 32, 14, 12}, 0, NONE},
    '{'{OP_UPDATE, 48'h0F0F_F0F0_0F0F, 1, 16, 200, 15}, 0, NONE},
    // Table is full: a new key is dropped, the last stored key still refreshes.
    '{'{OP_UPDATE, 48'h1234_5678_9ABC, 5, 5, 5, 0}, 1,
      '{bknt_pkg::ST_DROPPED, 0, 16, '{0, 0, 0, 0}}},
    '{'{OP_UPDATE, 48'h0F0F_F0F0_0F0F, 127, 0, 255, 0}, 0, NONE},
    '{'{OP_QUERY,  48'h0, 0, 0, 0, 15}, 0, NONE}
  };

  // Applies one item to the predictor table and returns the result the block should give.
  function automatic table_result_t predict_table(input scan_item_t it);
    table_result_t r;
    logic          hit;
    r = '0;
    r.status = bknt_pkg::ST_IGNORED;
    hit = 1'b0;
    if (it.op == OP_QUERY) begin
      if (it.pos < net_count) begin
        r.found = 1'b1;
        r.entry = net_entries[it.pos];
      end
    end else if (it.key != '0) begin
      for (int i = 0; i < bknt_pkg::MAX_NETWORKS; i++) begin
        if (!hit && i < net_count && net_entries[i].key == it.key) begin
          net_entries[i] = '{it.key, it.sig, it.sec, it.chan};
          r.status = bknt_pkg::ST_REFRESHED;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (net_count == bknt_pkg::CNT_W'(bknt_pkg::MAX_NETWORKS)) begin
          r.status = bknt_pkg::ST_DROPPED;
        end else begin
          net_entries[net_count] = '{it.key, it.sig, it.sec, it.chan};
          net_count = net_count + 1'b1;
          r.status = bknt_pkg::ST_APPENDED;
        end
      end
    end
    r.total = net_count;
    return r;
  endfunction

  // Random traffic leans on stored keys, so refreshes hit every table position; near-miss
  // keys exercise the full compare walk, and queries carry junk in the update fields.
  function automatic scan_item_t random_scan_item();
    scan_item_t it;
    int         pick;
    it.op   = OP_UPDATE;
    it.key  = bknt_pkg::KEY_W'({$urandom, $urandom});
    it.sig  = bknt_pkg::BYTE_W'($urandom);
    it.sec  = bknt_pkg::BYTE_W'($urandom);
    it.chan = bknt_pkg::BYTE_W'($urandom);
    it.pos  = bknt_pkg::POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = OP_QUERY;
    end else if (pick < 85 && net_count != 0) begin
      it.key = net_entries[$urandom_range(0, net_count - 1)].key;
      if (pick >= 75) begin
        it.key = it.key ^ (bknt_pkg::KEY_W'(1) << $urandom_range(0, bknt_pkg::KEY_W - 1));
      end
    end else if (pick >= 93) begin
      it.key = '0;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    end
  endtask

  // Sends one item in bursts with random gaps. Valid is lowered only when a gap starts,
  // and held with a stable payload until the block takes the transaction.
  task automatic drive_item(input scan_item_t it, input bit use_typed,
                            input table_result_t typed_want);
    table_result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid        <= 1'b1;
    operation       <= it.op;
    bssid           <= it.key;
    signal_strength <= it.sig;
    security_type   <= it.sec;
    radio_channel   <= it.chan;
    position        <= it.pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_table(it);
    if (it.op == OP_QUERY) begin
      if (predicted.found) query_hits++;
      else query_misses++;
    end else begin
      status_count[predicted.status]++;
    end
    expected_results.push_back(use_typed ? typed_want : predicted);
  endtask

  // Cycle count and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure: a new mode is drawn whenever the low six bits of the cycle count are zero.
  always @(posedge clk) begin
    if (cycle_count[5:0] == 6'd0) drain_mode <= drain_mode_t'($urandom_range(0, 3));
    case (drain_mode)
      DRAIN_ALWAYS:   out_ready <= 1'b1;
      DRAIN_COIN:     out_ready <= 1'($urandom);
      DRAIN_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      DRAIN_PERIODIC: out_ready <= (cycle_count[2:0] == 3'd0);
      default:        out_ready <= 1'b1;
    endcase
  end

  // Result checker: every result transaction is matched to the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, entry_total", 64'(entry_total), 64'd0);
      end else begin
        want_now = expected_results.pop_front();
        if (update_status !== want_now.status)
          report_mismatch("update_status", 64'(update_status), 64'(want_now.status));
        if (found !== want_now.found)
          report_mismatch("found", 64'(found), 64'(want_now.found));
        if (entry_total !== want_now.total)
          report_mismatch("entry_total", 64'(entry_total), 64'(want_now.total));
        if (bssid_out !== want_now.entry.key)
          report_mismatch("bssid_out", 64'(bssid_out), 64'(want_now.entry.key));
        if (signal_out !== want_now.entry.signal)
          report_mismatch("signal_out", 64'(signal_out), 64'(want_now.entry.signal));
        if (security_out !== want_now.entry.security)
          report_mismatch("security_out", 64'(security_out), 64'(want_now.entry.security));
        if (channel_out !== want_now.entry.channel)
          report_mismatch("channel_out", 64'(channel_out), 64'(want_now.entry.channel));
      end
    end
  end

  initial begin
    scan_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      drive_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    while (random_done < N_RANDOM) begin
      it = random_scan_item();
      drive_item(it, 1'b0, NONE);
      random_done++;
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d results: %0d appended, %0d refreshed, %0d dropped, %0d zero keys",
             results_seen, status_count[bknt_pkg::ST_APPENDED],
             status_count[bknt_pkg::ST_REFRESHED], status_count[bknt_pkg::ST_DROPPED],
             status_count[bknt_pkg::ST_IGNORED]);
    $display("queries: %0d hits, %0d misses; %0d mismatches", query_hits, query_misses,
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
